// File: hw/rtl/hbfd_pkg.sv
// hbfd_pkg: shared types, constants and helper functions for the HTTP body
// framing decoder. No dependencies.

package hbfd_pkg;

    // Field and state widths
    localparam int unsigned BYTE_W          = 8;
    localparam int unsigned STATUS_W        = 2;
    localparam int unsigned LENGTH_W        = 32;
    localparam int unsigned CHUNK_SIZE_BITS = 32;
    localparam int unsigned REM_W           =
        (CHUNK_SIZE_BITS > LENGTH_W) ? CHUNK_SIZE_BITS : LENGTH_W;
    localparam int unsigned BODY_COUNT_W    = 24;
    localparam int unsigned SKIP_W          = 2;
    localparam int unsigned CFG_INDEX_W     = 2;

    // Largest body accepted in length mode (10 MiB)
    localparam logic [BODY_COUNT_W:0] BODY_LIMIT = (BODY_COUNT_W + 1)'(10 * 1024 * 1024);

    // Bytes after each chunk's data that are dropped unchecked
    localparam logic [SKIP_W-1:0] CHUNK_TRAILER_LEN = SKIP_W'(2);

    // Character codes
    localparam logic [BYTE_W-1:0] CH_CR   = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF   = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_SP   = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TAB  = 8'h09;
    localparam logic [BYTE_W-1:0] CH_SEMI = 8'h3B;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_BODY_MODE   = 2'd0,
        CFG_BODY_LENGTH = 2'd1
    } cfg_index_t;

    // Framing modes
    typedef enum logic {
        MODE_LENGTH  = 1'b0,
        MODE_CHUNKED = 1'b1
    } body_mode_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_BUSY  = 2'd0,
        ST_DONE  = 2'd1,
        ST_BAD   = 2'd2,
        ST_LARGE = 2'd3
    } status_t;

    // Decoder phases
    typedef enum logic [3:0] {
        PH_START       = 4'd0,
        PH_LEN_BODY    = 4'd1,
        PH_LEN_TAIL    = 4'd2,
        PH_DONE_STRICT = 4'd3,
        PH_SIZE        = 4'd4,
        PH_SIZE_WS     = 4'd5,
        PH_SIZE_EXT    = 4'd6,
        PH_ZERO_TAIL   = 4'd7,
        PH_DATA        = 4'd8,
        PH_SKIP        = 4'd9,
        PH_DONE        = 4'd10,
        PH_ERR_BAD     = 4'd11,
        PH_ERR_LARGE   = 4'd12
    } phase_t;

    // Registered configuration seen by the core
    typedef struct packed {
        body_mode_t            body_mode;
        logic [LENGTH_W-1:0]   body_length;
    } cfg_t;

    // One result item
    typedef struct packed {
        logic                  body_valid;
        logic [BYTE_W-1:0]     body_byte;
        status_t               status;
    } result_t;

    // Hex digit decode: bit 4 flags a valid digit, bits 3:0 hold its value
    function automatic logic [4:0] hex_decode(input logic [BYTE_W-1:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b1, 4'(b - 8'h30)};
        end
        else if (b >= 8'h61 && b <= 8'h66) begin
            r = {1'b1, 4'(b - 8'h57)};
        end
        else if (b >= 8'h41 && b <= 8'h46) begin
            r = {1'b1, 4'(b - 8'h37)};
        end
        return r;
    endfunction

    // Status reported for a phase
    function automatic status_t phase_status(input phase_t ph);
        status_t s;
        case (ph)
            PH_LEN_TAIL, PH_DONE_STRICT, PH_DONE: s = ST_DONE;
            PH_ERR_BAD:                           s = ST_BAD;
            PH_ERR_LARGE:                         s = ST_LARGE;
            default:                              s = ST_BUSY;
        endcase
        return s;
    endfunction

endpackage

// File: hw/rtl/hbfd_cfg_regs.sv
// hbfd_cfg_regs: configuration register file (body mode, body length).
// Depends on hbfd_pkg.

module hbfd_cfg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [hbfd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [hbfd_pkg::LENGTH_W-1:0]      cfg_data,
    output hbfd_pkg::cfg_t                     cfg
);
    import hbfd_pkg::*;

    body_mode_t            body_mode_reg;
    body_mode_t            body_mode_next;
    logic [LENGTH_W-1:0]   body_length_reg;
    logic [LENGTH_W-1:0]   body_length_next;

    // Writes are always taken
    assign cfg_ready = 1'b1;

    // Register decode
    always_comb
    begin
        body_mode_next   = body_mode_reg;
        body_length_next = body_length_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_BODY_MODE:   body_mode_next   = body_mode_t'(cfg_data[0]);
                CFG_BODY_LENGTH: body_length_next = cfg_data;
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            body_mode_reg   <= MODE_LENGTH;
            body_length_reg <= '0;
        end
        else
        begin
            body_mode_reg   <= body_mode_next;
            body_length_reg <= body_length_next;
        end
    end

    assign cfg.body_mode   = body_mode_reg;
    assign cfg.body_length = body_length_reg;

endmodule

// File: hw/rtl/hbfd_core.sv
// hbfd_core: framing state machine; updates phase and counters on each
// accepted item and produces that item's result. Depends on hbfd_pkg.

module hbfd_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           accept,
    input  logic [hbfd_pkg::BYTE_W-1:0]    data_byte,
    input  logic                           restart,
    input  hbfd_pkg::cfg_t                 cfg,
    output hbfd_pkg::result_t              result
);
    import hbfd_pkg::*;

    phase_t                  phase_reg,      phase_next;
    logic [REM_W-1:0]        remaining_reg,  remaining_next;
    logic [BODY_COUNT_W-1:0] body_count_reg, body_count_next;
    logic                    digits_reg,     digits_next;
    logic                    pending_cr_reg, pending_cr_next;
    logic [SKIP_W-1:0]       skip_left_reg,  skip_left_next;

    phase_t                  eff_phase;
    logic [REM_W-1:0]        eff_rem;
    logic [REM_W-1:0]        rem_dec;
    logic [BODY_COUNT_W:0]   count_inc;
    logic                    over_limit;
    logic [4:0]              hex;
    logic                    is_ws;

    // Start phase resolves to a mode using the current configuration
    always_comb
    begin
        eff_phase = phase_reg;
        eff_rem   = remaining_reg;
        if (phase_reg == PH_START)
        begin
            if (cfg.body_mode == MODE_CHUNKED)
            begin
                eff_phase = PH_SIZE;
            end
            else if (cfg.body_length == '0)
            begin
                // empty body: byte is swallowed by completion
                eff_phase = PH_DONE;
            end
            else
            begin
                eff_phase = PH_LEN_BODY;
                eff_rem   = REM_W'(cfg.body_length);
            end
        end
    end

    assign rem_dec    = eff_rem - REM_W'(1);
    assign count_inc  = {1'b0, body_count_reg} + (BODY_COUNT_W + 1)'(1);
    assign over_limit = count_inc > BODY_LIMIT;
    assign hex        = hex_decode(data_byte);
    assign is_ws      = (data_byte == CH_SP) || (data_byte == CH_TAB);

    // Next state
    always_comb
    begin
        phase_next      = eff_phase;
        remaining_next  = eff_rem;
        body_count_next = body_count_reg;
        digits_next     = digits_reg;
        pending_cr_next = pending_cr_reg;
        skip_left_next  = skip_left_reg;
        if (restart)
        begin
            remaining_next  = '0;
            body_count_next = '0;
            digits_next     = 1'b0;
            pending_cr_next = 1'b0;
            skip_left_next  = '0;
            phase_next      = (cfg.body_mode == MODE_LENGTH && cfg.body_length == '0)
                              ? PH_DONE : PH_START;
        end
        else
        begin
            unique case (eff_phase)
                PH_LEN_BODY:
                begin
                    if (over_limit)
                    begin
                        phase_next = PH_ERR_LARGE;
                    end
                    else
                    begin
                        body_count_next = count_inc[BODY_COUNT_W-1:0];
                        remaining_next  = rem_dec;
                        if (rem_dec == '0)
                        begin
                            phase_next = PH_LEN_TAIL;
                        end
                    end
                end
                PH_LEN_TAIL, PH_ZERO_TAIL:
                begin
                    // expect exactly CR LF
                    if (pending_cr_reg)
                    begin
                        pending_cr_next = 1'b0;
                        if (data_byte != CH_LF)
                        begin
                            phase_next = PH_ERR_BAD;
                        end
                        else
                        begin
                            phase_next = (eff_phase == PH_LEN_TAIL) ? PH_DONE_STRICT : PH_DONE;
                        end
                    end
                    else if (data_byte == CH_CR)
                    begin
                        pending_cr_next = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_ERR_BAD;
                    end
                end
                PH_DONE_STRICT:
                begin
                    phase_next = PH_ERR_BAD;
                end
                PH_SIZE, PH_SIZE_WS, PH_SIZE_EXT:
                begin
                    if (pending_cr_reg)
                    begin
                        // line end: LF with at least one digit
                        pending_cr_next = 1'b0;
                        if (data_byte != CH_LF || !digits_reg)
                        begin
                            phase_next = PH_ERR_BAD;
                        end
                        else
                        begin
                            digits_next = 1'b0;
                            phase_next  = (eff_rem == '0) ? PH_ZERO_TAIL : PH_DATA;
                        end
                    end
                    else if (data_byte == CH_CR)
                    begin
                        pending_cr_next = 1'b1;
                    end
                    else if (eff_phase == PH_SIZE_EXT)
                    begin
                        // extension text is ignored
                    end
                    else if (data_byte == CH_SEMI)
                    begin
                        phase_next = PH_SIZE_EXT;
                    end
                    else if (is_ws)
                    begin
                        if (digits_reg)
                        begin
                            phase_next = PH_SIZE_WS;
                        end
                    end
                    else if (eff_phase != PH_SIZE || !hex[4])
                    begin
                        phase_next = PH_ERR_BAD;
                    end
                    else if (eff_rem[REM_W-1:CHUNK_SIZE_BITS-4] != '0)
                    begin
                        // one more digit would overflow the size
                        phase_next = PH_ERR_BAD;
                    end
                    else
                    begin
                        remaining_next = {eff_rem[REM_W-5:0], hex[3:0]};
                        digits_next    = 1'b1;
                    end
                end
                PH_DATA:
                begin
                    remaining_next = rem_dec;
                    if (rem_dec == '0)
                    begin
                        phase_next     = PH_SKIP;
                        skip_left_next = CHUNK_TRAILER_LEN;
                    end
                end
                PH_SKIP:
                begin
                    skip_left_next = skip_left_reg - SKIP_W'(1);
                    if (skip_left_next == '0)
                    begin
                        phase_next = PH_SIZE;
                    end
                end
                default:
                begin
                    // done phases ignore bytes, errors are sticky
                end
            endcase
        end
    end

    // Result outputs
    always_comb
    begin
        result.body_valid = 1'b0;
        if (!restart)
        begin
            result.body_valid = (eff_phase == PH_DATA) ||
                                (eff_phase == PH_LEN_BODY && !over_limit);
        end
        result.body_byte = result.body_valid ? data_byte : '0;
        result.status    = phase_status(phase_next);
    end

    // State registers, updated on accepted items only
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_START;
            remaining_reg  <= '0;
            body_count_reg <= '0;
            digits_reg     <= 1'b0;
            pending_cr_reg <= 1'b0;
            skip_left_reg  <= '0;
        end
        else if (accept)
        begin
            phase_reg      <= phase_next;
            remaining_reg  <= remaining_next;
            body_count_reg <= body_count_next;
            digits_reg     <= digits_next;
            pending_cr_reg <= pending_cr_next;
            skip_left_reg  <= skip_left_next;
        end
    end

endmodule

// File: hw/rtl/hbfd_out_reg.sv
// hbfd_out_reg: result register between the core and the output channel;
// takes a new item whenever the held one is gone or leaving. Depends on hbfd_pkg.

module hbfd_out_reg (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  hbfd_pkg::result_t     result,
    output logic                  out_valid,
    input  logic                  out_ready,
    output hbfd_pkg::result_t     result_out
);
    import hbfd_pkg::*;

    logic      out_valid_reg;
    logic      out_valid_next;
    result_t   result_reg;
    logic      load;

    // Free slot, or the held item leaves this cycle
    assign in_ready = !out_valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload needs no reset
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign out_valid  = out_valid_reg;
    assign result_out = result_reg;

endmodule

// File: hw/rtl/http_body_framing_decoder.sv
// http_body_framing_decoder: top level; frames HTTP body bytes in length or
// chunked mode. Depends on hbfd_pkg, hbfd_cfg_regs, hbfd_core, hbfd_out_reg.
// Latency: result is valid the cycle after its item is accepted.
// Throughput: one item per cycle while out_ready is high; the single result register sets the pace.
// Reset: rst_n clears configuration, decoder state and the result register's valid flag.

module http_body_framing_decoder (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [hbfd_pkg::BYTE_W-1:0]        data_byte,
    input  logic                               restart,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               body_valid,
    output logic [hbfd_pkg::BYTE_W-1:0]        body_byte,
    output logic [hbfd_pkg::STATUS_W-1:0]      status,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [hbfd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [hbfd_pkg::LENGTH_W-1:0]      cfg_data
);
    import hbfd_pkg::*;

    cfg_t      cfg;
    result_t   core_result;
    result_t   out_result;
    logic      accept;

    assign accept = in_valid && in_ready;

    hbfd_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    hbfd_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (data_byte),
        .restart   (restart),
        .cfg       (cfg),
        .result    (core_result)
    );

    hbfd_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .result     (core_result),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .result_out (out_result)
    );

    assign body_valid = out_result.body_valid;
    assign body_byte  = out_result.body_byte;
    assign status     = out_result.status;

endmodule
